// ===== rtl/askf_pkg.sv =====
package askf_pkg;
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 24;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int ROOT_W    = (VAL_W + FRAC_BITS + 1) / 2;
  localparam int MUL_W     = 2 * VAL_W;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_SLOPE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_KNEE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FLOOR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VARIANCE  = 3'd6;

  localparam logic [VAL_W-1:0] RST_PROCESS_NOISE = 24'd6554;
  localparam logic [VAL_W-1:0] RST_NOISE_GAIN    = 24'd6554;
  localparam logic [VAL_W-1:0] RST_THR_SLOPE     = 24'd1610;
  localparam logic [VAL_W-1:0] RST_THR_OFFSET    = 24'd179765;
  localparam logic [VAL_W-1:0] RST_THR_KNEE      = 24'd655360;
  localparam logic [VAL_W-1:0] RST_THR_FLOOR     = 24'd327680;
  localparam logic [VAL_W-1:0] RST_INIT_VARIANCE = 24'd131072;

  function automatic logic [VAL_W-1:0] sat24(input logic [MUL_W-1:0] v);
    logic [VAL_W-1:0] r;
    r = (v > MUL_W'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
    return r;
  endfunction
endpackage

// ===== rtl/askf_mul.sv =====
module askf_mul
  import askf_pkg::*;
(
  input  logic             clk,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic [MUL_W-1:0] p_r
);
  // shared 24x24 multiplier, registered product
  always_ff @(posedge clk) begin
    p_r <= MUL_W'(a) * MUL_W'(b);
  end
endmodule

// ===== rtl/askf_div.sv =====
module askf_div
  import askf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [VAL_W+FRAC_BITS-1:0] num,
  input  logic [VAL_W:0]             den,
  output logic                       busy_r,
  output logic [VAL_W+FRAC_BITS-1:0] quot_r
);
  localparam int NW = VAL_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  // restoring divider, one quotient bit a cycle
  logic [VAL_W+1:0] rem_r;
  logic [CW-1:0]    cnt_r;
  logic [VAL_W+1:0] trial;

  assign trial = {rem_r[VAL_W:0], quot_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      rem_r  <= '0;
      quot_r <= num;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_r  <= trial - {1'b0, den};
        quot_r <= {quot_r[NW-2:0], 1'b1};
      end else begin
        rem_r  <= trial;
        quot_r <= {quot_r[NW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/adaptive_scalar_kalman_filter.sv =====
// sequence: an accepted request runs S_SQRT (square root), S_MR (noise product),
// S_MTHR and S_DIV (threshold product and gain divider), S_GAIN, S_M1 to S_M4 (blend
// and variance products) and then S_OUT with out_valid; throughput: one request at a time;
// a new one is taken once the result has gone, so a stalled result holds the input off
// the square root is bit-serial and the divider takes one quotient bit a cycle
// reset: synchronous active-low rst_n clears state, started flag and control,
// and loads the register reset values
module adaptive_scalar_kalman_filter
  import askf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [VAL_W-1:0]     in_measurement,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VAL_W-1:0]     out_estimate,
  output logic                 out_outlier_taken,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);
  localparam int SQ_W  = 2 * ROOT_W;
  localparam int SQ_CW = $clog2(ROOT_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_MR, S_MTHR, S_DIV, S_GAIN,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [VAL_W-1:0] q_r, ngain_r, slope_r, offs_r, knee_r, floor_r, pinit_r;

  // filter state
  logic [VAL_W-1:0] est_r, var_r;
  logic             started_r;

  // per-request working values
  logic [VAL_W-1:0]  meas_r, xp_r, p_r, pp_r, r_r, thr_r;
  logic [GAIN_W-1:0] g_r;
  logic              seed_r, outl_r;
  logic [MUL_W:0]    acc_r;

  // square root: bit pair per cycle
  logic [SQ_W-1:0]   sq_v_r;
  logic [ROOT_W+1:0] sq_rem_r;
  logic [ROOT_W-1:0] sq_root_r;
  logic [SQ_CW-1:0]  sq_cnt_r;
  logic [ROOT_W+1:0] sq_trial;

  // shared multiplier
  logic [VAL_W-1:0] mul_a, mul_b;
  logic [MUL_W-1:0] mul_p;

  // gain divider
  logic                       div_start;
  logic                       div_busy;
  logic [VAL_W+FRAC_BITS-1:0] div_quot;
  logic [VAL_W:0]             den;

  logic [VAL_W-1:0]  innov;
  logic [VAL_W-1:0]  one_m_g;
  logic [MUL_W:0]    blend;

  askf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  askf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num({pp_r, FRAC_BITS'(0)}), .den(den),
    .busy_r(div_busy), .quot_r(div_quot)
  );

  assign den      = {1'b0, p_r} + {1'b0, r_r};
  assign sq_trial = {sq_rem_r[ROOT_W-1:0], sq_v_r[SQ_W-1 -: 2]} - {sq_root_r, 2'b01};
  assign innov    = (meas_r > xp_r) ? meas_r - xp_r : xp_r - meas_r;
  assign one_m_g  = VAL_W'(GAIN_ONE - g_r);
  assign blend    = acc_r + {1'b0, mul_p};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // multiplier operand select by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MR:   begin mul_a = ngain_r; mul_b = VAL_W'(sq_root_r); end
      // threshold product held while the divider runs
      S_MTHR, S_DIV: begin mul_a = slope_r; mul_b = xp_r; end
      S_M1:   begin mul_a = VAL_W'(outl_r ? g_r : GAIN_W'(one_m_g)); mul_b = xp_r; end
      S_M2:   begin mul_a = VAL_W'(outl_r ? GAIN_W'(one_m_g) : g_r); mul_b = meas_r; end
      S_M3:   begin mul_a = one_m_g; mul_b = pp_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign div_start = (state_r == S_MTHR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      est_r     <= '0;
      var_r     <= '0;
      started_r <= 1'b0;
      q_r       <= RST_PROCESS_NOISE;
      ngain_r   <= RST_NOISE_GAIN;
      slope_r   <= RST_THR_SLOPE;
      offs_r    <= RST_THR_OFFSET;
      knee_r    <= RST_THR_KNEE;
      floor_r   <= RST_THR_FLOOR;
      pinit_r   <= RST_INIT_VARIANCE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROCESS_NOISE: q_r     <= cfg_data;
          REG_NOISE_GAIN:    ngain_r <= cfg_data;
          REG_THR_SLOPE:     slope_r <= cfg_data;
          REG_THR_OFFSET:    offs_r  <= cfg_data;
          REG_THR_KNEE:      knee_r  <= cfg_data;
          REG_THR_FLOOR:     floor_r <= cfg_data;
          REG_INIT_VARIANCE: pinit_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            // prediction: seed on first request
            meas_r    <= in_measurement;
            seed_r    <= !started_r;
            xp_r      <= started_r ? est_r : in_measurement;
            p_r       <= started_r ? var_r : pinit_r;
            pp_r      <= sat24(MUL_W'(started_r ? var_r : pinit_r) + MUL_W'(q_r));
            sq_v_r    <= {(started_r ? est_r : in_measurement), FRAC_BITS'(0)};
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= SQ_CW'(ROOT_W);
            state_r   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (!sq_trial[ROOT_W+1]) begin
            sq_rem_r  <= sq_trial;
            sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem_r  <= {sq_rem_r[ROOT_W-1:0], sq_v_r[SQ_W-1 -: 2]};
            sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b0};
          end
          sq_v_r   <= {sq_v_r[SQ_W-3:0], 2'b00};
          sq_cnt_r <= sq_cnt_r - SQ_CW'(1);
          if (sq_cnt_r == SQ_CW'(1)) begin
            state_r <= S_MR;
          end
        end
        S_MR: begin
          state_r <= S_MTHR;
        end
        S_MTHR: begin
          // noise product ready; the divider is started in this state and its steps use the new r
          r_r     <= sat24(mul_p >> FRAC_BITS);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            thr_r   <= (xp_r < knee_r) ? floor_r
                       : sat24((mul_p >> FRAC_BITS) + MUL_W'(offs_r));
            state_r <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (den == '0 || div_quot > (VAL_W + FRAC_BITS)'(GAIN_ONE)) begin
            g_r <= GAIN_ONE;
          end else begin
            g_r <= div_quot[GAIN_W-1:0];
          end
          outl_r  <= !seed_r && (innov > thr_r);
          state_r <= S_M1;
        end
        S_M1: begin
          acc_r   <= '0;
          state_r <= S_M2;
        end
        S_M2: begin
          acc_r   <= {1'b0, mul_p};
          state_r <= S_M3;
        end
        S_M3: begin
          est_r   <= VAL_W'(blend >> FRAC_BITS);
          state_r <= S_M4;
        end
        S_M4: begin
          var_r     <= VAL_W'(mul_p >> FRAC_BITS);
          started_r <= 1'b1;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_estimate      = est_r;
  assign out_outlier_taken = outl_r;

  // no request taken while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request accepted while busy");

  // a seeding request never flags an outlier
  a_seed_no_outlier: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && seed_r) |-> !out_outlier_taken) else $error("outlier on seed");

  // gain never above one once computed
  a_gain_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (g_r <= GAIN_ONE)) else $error("gain above one");
endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import askf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 100;

  typedef enum int {
    PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH
  } idle_phase_t;

  typedef struct packed {
    logic [VAL_W-1:0] estimate;
    logic             outlier_taken;
  } kf_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VAL_W-1:0] in_measurement = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VAL_W-1:0] out_estimate;
  logic out_outlier_taken;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;

  // predictor state and register copy
  logic [VAL_W-1:0] filt_regs [7];
  logic [VAL_W-1:0] filt_estimate;
  logic [VAL_W-1:0] filt_variance;
  logic             filt_started;

  logic [VAL_W-1:0] meas_queue [$];
  kf_result_t       expected_results [$];
  int               mismatch_count = 0;
  idle_phase_t      idle_phase = PH_FREE;
  bit               hold_receiver = 1'b0;
  bit               hold_sender = 1'b0;
  bit               in_taken = 1'b0;

  adaptive_scalar_kalman_filter i_dut (.*);

  always #10 clk = ~clk;

  // integer square root by bit pairs
  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] clip24(input logic [63:0] v);
    return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
  endfunction

  // one filter step: predict, adapt noise, gain, outlier test, blend, variance update
  function automatic kf_result_t filter_step(input logic [VAL_W-1:0] meas);
    logic [63:0] xp, p, pp, s, r, den, g, thr, innov, x, one;
    bit seeding;
    bit outlier;
    kf_result_t res;
    one = 64'd1 << FRAC_BITS;
    seeding = !filt_started;
    outlier = 1'b0;
    xp = seeding ? 64'(meas) : 64'(filt_estimate);
    p  = seeding ? 64'(filt_regs[REG_INIT_VARIANCE]) : 64'(filt_variance);
    pp = clip24(p + filt_regs[REG_PROCESS_NOISE]);
    s  = int_root(xp << FRAC_BITS);
    r  = clip24((64'(filt_regs[REG_NOISE_GAIN]) * s) >> FRAC_BITS);
    den = p + r;
    if (den == 0) begin
      g = one;
    end else begin
      g = (pp << FRAC_BITS) / den;
      if (g > one) g = one;
    end
    if (!seeding) begin
      if (xp < filt_regs[REG_THR_KNEE])
        thr = filt_regs[REG_THR_FLOOR];
      else
        thr = clip24(((64'(filt_regs[REG_THR_SLOPE]) * xp) >> FRAC_BITS)
                     + filt_regs[REG_THR_OFFSET]);
      innov = (meas > xp) ? meas - xp : xp - meas;
      outlier = innov > thr;
    end
    if (outlier)
      x = (g * xp + (one - g) * meas) >> FRAC_BITS;
    else
      x = ((one - g) * xp + g * meas) >> FRAC_BITS;
    filt_estimate = x[VAL_W-1:0];
    filt_variance = 24'(((one - g) * pp) >> FRAC_BITS);
    filt_started = 1'b1;
    res.estimate = filt_estimate;
    res.outlier_taken = outlier;
    return res;
  endfunction

  // request and receiver stall driver, changes on falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      // a new request only once the previous one was taken at the last rising edge
      if (!in_valid || in_taken) begin
        if (meas_queue.size() > 0 && !hold_sender &&
            !((idle_phase == PH_SEND_IDLE || idle_phase == PH_BOTH) &&
              $urandom_range(99) < 77)) begin
          in_valid <= 1'b1;
          in_measurement <= meas_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= hold_receiver ||
        ((idle_phase == PH_RECV_STALL || idle_phase == PH_BOTH) &&
         $urandom_range(99) < 77);
    end
  end

  // prediction on acceptance, checking on result
  always @(posedge clk) begin
    kf_result_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(filter_step(in_measurement));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result est=%h outlier=%b", out_estimate, out_outlier_taken);
      end else begin
        want = expected_results.pop_front();
        if (want.estimate !== out_estimate || want.outlier_taken !== out_outlier_taken) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected est=%h outlier=%b, got est=%h outlier=%b",
                     want.estimate, want.outlier_taken, out_estimate, out_outlier_taken);
        end
      end
    end
  end

  // wait until every queued request has been taken and answered
  task automatic drain();
    while (meas_queue.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    filt_regs[idx] = val;
  endtask

  function automatic logic [VAL_W-1:0] rand_meas();
    case ($urandom_range(3))
      0: return VAL_W'($urandom);
      1: return VAL_W'($urandom_range(24'h1FFFFF));
      default: return VAL_W'(($urandom_range(20, 40) << FRAC_BITS) + $urandom_range(16'hFFFF));
    endcase
  endfunction

  // a burst of values jittering around one base with occasional spikes
  task automatic queue_burst(input int n);
    logic [VAL_W-1:0] base;
    base = rand_meas();
    repeat (n) begin
      if ($urandom_range(9) == 0)
        meas_queue.push_back(rand_meas());
      else
        meas_queue.push_back(base + VAL_W'($urandom_range(8000)) - VAL_W'(4000));
    end
  endtask

  // run-time limit
  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    filt_regs[REG_PROCESS_NOISE] = RST_PROCESS_NOISE;
    filt_regs[REG_NOISE_GAIN]    = RST_NOISE_GAIN;
    filt_regs[REG_THR_SLOPE]     = RST_THR_SLOPE;
    filt_regs[REG_THR_OFFSET]    = RST_THR_OFFSET;
    filt_regs[REG_THR_KNEE]      = RST_THR_KNEE;
    filt_regs[REG_THR_FLOOR]     = RST_THR_FLOOR;
    filt_regs[REG_INIT_VARIANCE] = RST_INIT_VARIANCE;
    filt_estimate = '0;
    filt_variance = '0;
    filt_started = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: seeding, extremes, spikes above and below the knee
    meas_queue = '{24'd0, 24'd0, VAL_MAX, 24'd0, 24'h140000, 24'h141000,
                   24'h200000, 24'h140000, 24'h800000, 24'h7F0000, 24'h000001,
                   24'hAAAAAA, 24'h555555};
    drain();

    // zero noise and zero variance hit the zero denominator; extreme registers
    write_reg(REG_PROCESS_NOISE, 24'd0);
    write_reg(REG_NOISE_GAIN, 24'd0);
    write_reg(REG_INIT_VARIANCE, 24'd0);
    meas_queue = '{24'd0, 24'h100000, 24'h000000};
    drain();
    write_reg(REG_PROCESS_NOISE, VAL_MAX);
    write_reg(REG_NOISE_GAIN, VAL_MAX);
    write_reg(REG_THR_SLOPE, VAL_MAX);
    write_reg(REG_THR_OFFSET, VAL_MAX);
    write_reg(REG_THR_KNEE, VAL_MAX);
    write_reg(REG_THR_FLOOR, 24'd0);
    write_reg(REG_INIT_VARIANCE, VAL_MAX);
    meas_queue = '{VAL_MAX, 24'd0, VAL_MAX, 24'h010000};
    drain();

    // random phases with random register settings
    for (int ph = 0; ph < 8; ph++) begin
      idle_phase = idle_phase_t'(ph % 4);
      for (int k = 0; k < 7; k++)
        write_reg(CFG_IDX_W'(k), ($urandom_range(3) == 0) ? VAL_W'($urandom)
                                 : VAL_W'($urandom_range(24'h0FFFFF)));
      if (ph == 2) begin
        // long receiver hold-off, timed in its own process while requests keep coming
        queue_burst(20);
        fork
          begin
            hold_receiver = 1'b1;
            repeat (300) @(posedge clk);
            hold_receiver = 1'b0;
          end
        join_none
      end
      queue_burst(75);
      if (ph == 5) begin
        // sender pauses until all results are back
        while (meas_queue.size() > 0 || in_valid) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
        queue_burst(5);
      end
      drain();
    end

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
